/* design/iir_lpf_pkg.sv */
// Shared constants, command codes and types for the biquad low-pass filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package iir_lpf_pkg;

   // Number of feedforward taps (2 or 3); feedback uses taps 1 to TAPS-1.
   localparam int TAPS = 3;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 32;
   localparam int CSR_IDX_W = 3;

   // Multiplier operand A is wide enough for the rounded feedforward sum.
   localparam int MUL_A_W = 33;
   localparam int PROD_W  = MUL_A_W + COEF_W;
   localparam int FF_W    = 49;
   localparam int ACC_W   = 52;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_B0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_A1   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_A2   = 3'd5;

   localparam logic signed [COEF_W-1:0] RST_GAIN = 32'sd1073741824;
   localparam logic signed [COEF_W-1:0] RST_B0   = 32'sd5951437;
   localparam logic signed [COEF_W-1:0] RST_B1   = 32'sd11902874;
   localparam logic signed [COEF_W-1:0] RST_B2   = 32'sd5951437;
   localparam logic signed [COEF_W-1:0] RST_A1   = -32'sd1909791329;
   localparam logic signed [COEF_W-1:0] RST_A2   = 32'sd859855294;

   // Multiplier operand selection.
   localparam logic [2:0] MSEL_X0   = 3'd0;
   localparam logic [2:0] MSEL_X1   = 3'd1;
   localparam logic [2:0] MSEL_X2   = 3'd2;
   localparam logic [2:0] MSEL_Y1   = 3'd3;
   localparam logic [2:0] MSEL_Y2   = 3'd4;
   localparam logic [2:0] MSEL_GAIN = 3'd5;

   // Where the registered product goes in the following cycle.
   localparam logic [2:0] DST_NONE    = 3'd0;
   localparam logic [2:0] DST_FF_LOAD = 3'd1;
   localparam logic [2:0] DST_FF_ADD  = 3'd2;
   localparam logic [2:0] DST_FB_SUB  = 3'd3;
   localparam logic [2:0] DST_GAIN    = 3'd4;

   typedef struct packed {
      logic       start;
      logic [2:0] mul_sel;
      logic [2:0] dest;
      logic       store;
   } dp_cmd_type;

endpackage

/* design/iir_lpf_ctrl.sv */
// Sequencer for the biquad filter: steps the shared multiplier through the taps
// and owns the item handshakes. Depends on iir_lpf_pkg.
module iir_lpf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output iir_lpf_pkg::dp_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_B0   = 4'd1;
   localparam logic [3:0] ST_B1   = 4'd2;
   localparam logic [3:0] ST_B2   = 4'd3;
   localparam logic [3:0] ST_A1   = 4'd4;
   localparam logic [3:0] ST_A2   = 4'd5;
   localparam logic [3:0] ST_G    = 4'd6;
   localparam logic [3:0] ST_WAIT = 4'd7;
   localparam logic [3:0] ST_DONE = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.start   = 1'b0;
      cmd.mul_sel = iir_lpf_pkg::MSEL_X0;
      cmd.dest    = iir_lpf_pkg::DST_NONE;
      cmd.store   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_B0;
            end
         end
         ST_B0: begin
            cmd.mul_sel = iir_lpf_pkg::MSEL_X0;
            cmd.dest    = iir_lpf_pkg::DST_FF_LOAD;
            state_in    = ST_B1;
         end
         ST_B1: begin
            cmd.mul_sel = iir_lpf_pkg::MSEL_X1;
            cmd.dest    = iir_lpf_pkg::DST_FF_ADD;
            state_in    = (iir_lpf_pkg::TAPS == 3) ? ST_B2 : ST_A1;
         end
         ST_B2: begin
            cmd.mul_sel = iir_lpf_pkg::MSEL_X2;
            cmd.dest    = iir_lpf_pkg::DST_FF_ADD;
            state_in    = ST_A1;
         end
         ST_A1: begin
            cmd.mul_sel = iir_lpf_pkg::MSEL_Y1;
            cmd.dest    = iir_lpf_pkg::DST_FB_SUB;
            state_in    = ST_A2;
         end
         ST_A2: begin
            // With two taps this step only gives the rounded feedforward sum
            // time to settle in its register.
            cmd.mul_sel = iir_lpf_pkg::MSEL_Y2;
            cmd.dest    = (iir_lpf_pkg::TAPS == 3) ? iir_lpf_pkg::DST_FB_SUB
                                                   : iir_lpf_pkg::DST_NONE;
            state_in    = ST_G;
         end
         ST_G: begin
            cmd.mul_sel = iir_lpf_pkg::MSEL_GAIN;
            cmd.dest    = iir_lpf_pkg::DST_GAIN;
            state_in    = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.store = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.store) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/iir_lpf_dp.sv */
// Datapath of the biquad filter: coefficient registers, sample and output
// history, one shared multiplier and the accumulators. Depends on iir_lpf_pkg.
module iir_lpf_dp (
   input  logic                                      clock,
   input  logic                                      reset,
   input  iir_lpf_pkg::dp_cmd_type                   cmd,
   input  logic [iir_lpf_pkg::SAMPLE_W-1:0]          sample_in,
   input  logic                                      csr_write,
   input  logic [iir_lpf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [iir_lpf_pkg::COEF_W-1:0]            csr_data,
   output logic [iir_lpf_pkg::SAMPLE_W-1:0]          sample_out
);

   localparam int SW = iir_lpf_pkg::SAMPLE_W;
   localparam int CW = iir_lpf_pkg::COEF_W;
   localparam int AW = iir_lpf_pkg::MUL_A_W;
   localparam int PW = iir_lpf_pkg::PROD_W;
   localparam int FW = iir_lpf_pkg::FF_W;
   localparam int QW = iir_lpf_pkg::ACC_W;

   logic signed [CW-1:0] gain_ff, b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [SW-1:0] x0_ff, x1_ff, x2_ff, y1_ff, y2_ff;
   logic signed [SW-1:0] out_ff, out_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic        [2:0]    dst_ff;
   logic signed [FW-1:0] ff_ff, ff_in, ff_rnd;
   logic signed [AW-1:0] ffr_ff;
   logic signed [QW-1:0] acc_ff, acc_in, gt;
   logic signed [PW-1:0] prod_rnd;
   logic signed [AW-1:0] mul_a;
   logic signed [CW-1:0] mul_b;
   logic signed [QW-31:0] res_raw;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= iir_lpf_pkg::RST_GAIN;
         b0_ff   <= iir_lpf_pkg::RST_B0;
         b1_ff   <= iir_lpf_pkg::RST_B1;
         b2_ff   <= iir_lpf_pkg::RST_B2;
         a1_ff   <= iir_lpf_pkg::RST_A1;
         a2_ff   <= iir_lpf_pkg::RST_A2;
      end else if (csr_write) begin
         case (csr_index)
            iir_lpf_pkg::REG_GAIN: gain_ff <= csr_data;
            iir_lpf_pkg::REG_B0:   b0_ff   <= csr_data;
            iir_lpf_pkg::REG_B1:   b1_ff   <= csr_data;
            iir_lpf_pkg::REG_B2:   b2_ff   <= csr_data;
            iir_lpf_pkg::REG_A1:   a1_ff   <= csr_data;
            iir_lpf_pkg::REG_A2:   a2_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (cmd.mul_sel)
         iir_lpf_pkg::MSEL_X0: begin
            mul_a = AW'(x0_ff);
            mul_b = b0_ff;
         end
         iir_lpf_pkg::MSEL_X1: begin
            mul_a = AW'(x1_ff);
            mul_b = b1_ff;
         end
         iir_lpf_pkg::MSEL_X2: begin
            mul_a = AW'(x2_ff);
            mul_b = b2_ff;
         end
         iir_lpf_pkg::MSEL_Y1: begin
            mul_a = AW'(y1_ff);
            mul_b = a1_ff;
         end
         iir_lpf_pkg::MSEL_Y2: begin
            mul_a = AW'(y2_ff);
            mul_b = a2_ff;
         end
         iir_lpf_pkg::MSEL_GAIN: begin
            mul_a = ffr_ff;
            mul_b = gain_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PW'(mul_a) * PW'(mul_b);

   // Round the feedforward sum to Q.14 and the gain product back to Q.30;
   // part-selects of the biased sums give the floor shifts.
   assign ff_rnd   = ff_ff + FW'(32768);
   assign prod_rnd = prod_ff + PW'(8192);
   assign gt       = QW'($signed(prod_rnd[PW-1:14]));

   always_comb begin
      ff_in  = ff_ff;
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = QW'(64'sd536870912);
      end
      case (dst_ff)
         iir_lpf_pkg::DST_FF_LOAD: ff_in  = prod_ff[FW-1:0];
         iir_lpf_pkg::DST_FF_ADD:  ff_in  = ff_ff + prod_ff[FW-1:0];
         iir_lpf_pkg::DST_FB_SUB:  acc_in = acc_ff - prod_ff[QW-1:0];
         iir_lpf_pkg::DST_GAIN:    acc_in = acc_ff + gt;
         default: ;
      endcase
   end

   // The accumulator already carries the half-unit bias, so the top bits are
   // the rounded result before saturation.
   assign res_raw = acc_ff[QW-1:30];

   always_comb begin
      if (res_raw > (QW-30)'(32767)) begin
         out_in = 16'sh7FFF;
      end else if (res_raw < -(QW-30)'(32768)) begin
         out_in = 16'sh8000;
      end else begin
         out_in = res_raw[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ff_ff   <= ff_in;
      ffr_ff  <= ff_rnd[FW-1:16];
      acc_ff  <= acc_in;
      if (cmd.start) begin
         x0_ff <= sample_in;
      end
      if (cmd.store) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dst_ff <= iir_lpf_pkg::DST_NONE;
         x1_ff  <= '0;
         x2_ff  <= '0;
         y1_ff  <= '0;
         y2_ff  <= '0;
      end else begin
         dst_ff <= cmd.dest;
         if (cmd.store) begin
            x2_ff <= x1_ff;
            x1_ff <= x0_ff;
            y2_ff <= y1_ff;
            y1_ff <= out_in;
         end
      end
   end

   assign sample_out = out_ff;

endmodule

/* design/iir_low_pass_filter_core.sv */
// Top level of the second-order direct form I low-pass filter.
// Depends on iir_lpf_pkg, iir_lpf_ctrl and iir_lpf_dp.
//
// Each item on the request stream is one signed 16-bit sample and produces one
// signed 16-bit filtered sample on the response stream. Coefficients and gain
// are signed Q2.30 values written through the csr port (index 0 gain, 1 to 3
// b0 to b2, 4 and 5 a1 and a2; other indexes are ignored); the user must write
// them only while the filter is idle, which the block itself does not enforce.
// One multiplier is shared by all taps and the gain, so an item steps through
// B0, B1, B2 (three taps only), A1, A2, gain, wait and done, where the result
// is loaded into the output register; the next item is accepted on the cycle
// after that load, not before. A result waits in that register until taken;
// the next item is accepted meanwhile but finishes only once it is free.
module iir_low_pass_filter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,  // [15:0] sample_in
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata,  // [15:0] sample_out
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [iir_lpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [iir_lpf_pkg::COEF_W-1:0]       csr_data
);

   iir_lpf_pkg::dp_cmd_type cmd;

   assign csr_ready = 1'b1;

   iir_lpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   iir_lpf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample_in  (req_tdata),
      .csr_write  (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .sample_out (rsp_tdata)
   );

endmodule

/* design/iir_lpf_checker.sv */
// Port-level checks for the biquad filter core, attached by a bind statement.
// Depends only on the top level's ports.
module iir_lpf_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_ready
);

   // A result that is not taken stays on offer unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed or dropped while stalled");

   // The filter stays busy with an item after taking it and does not take the next one straight away.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken again straight after an item");

   // No new result can appear in the cycle after an item is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared too early");

   // Nothing is offered on the response side straight after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid high after reset");

   // Configuration writes are always taken.
   assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr port not ready");

endmodule

bind iir_low_pass_filter_core iir_lpf_port_checker u_iir_lpf_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);
